// ===== rtl/psec_pkg.sv =====
package psec_pkg;

	// angle word and iteration count
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	// apb byte address width, six 32-bit registers
	localparam int ADDR_W = 5;

	// coordinate difference and cordic datapath widths
	localparam int DW     = 25;
	localparam int SQW    = 2 * DW - 2;
	localparam int CW     = 58;
	localparam int PRE_SH = 30;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	// half angle degrees q7.8 to turn fraction: full turn is 2 * 180 * 256 = 2^11 * 45
	localparam int DEG_FULL = 2 * 180 * 256;
	localparam int DEG_BIAS = DEG_FULL / 2;
	localparam int DEG_SH   = 11;
	localparam int DEG_ODD  = DEG_FULL / (1 << DEG_SH);
	localparam int HSW      = ANGLE_BITS + 16;
	localparam int HNW      = HSW - DEG_SH;
	localparam int RCK      = ANGLE_BITS + DEG_SH;
	localparam int RCW      = ANGLE_BITS + 7;
	localparam longint unsigned RECIP_L = ((64'd1 << RCK) + DEG_ODD - 1) / DEG_ODD;
	localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);

	typedef struct packed {
		logic                  vld;
		logic [ANGLE_BITS-1:0] angle;
	} bear_t;

endpackage

// ===== rtl/psec_cordic.sv =====
module psec_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vld_in,
	input  logic signed [psec_pkg::DW-1:0] x_in,
	input  logic signed [psec_pkg::DW-1:0] y_in,
	output psec_pkg::bear_t                bear
);
	import psec_pkg::*;

	localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);

	logic                 vld_s  [NSTEP+1];
	logic                 zero_s [NSTEP+1];
	logic signed [CW-1:0] x_s    [NSTEP+1];
	logic signed [CW-1:0] y_s    [NSTEP+1];
	logic [31:0]          z_s    [NSTEP+1];

	logic signed [CW-1:0]  xw;
	logic signed [CW-1:0]  yw;
	logic [31:0]           rsum;
	logic                  vld_q;
	logic [ANGLE_BITS-1:0] ang_q;

	assign xw   = {{(CW-DW){x_in[DW-1]}}, x_in} <<< PRE_SH;
	assign yw   = {{(CW-DW){y_in[DW-1]}}, y_in} <<< PRE_SH;
	assign rsum = z_s[NSTEP] + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTEP; k++) begin
				vld_s[k] <= 1'b0;
			end
			vld_q <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
			for (int k = 0; k < NSTEP; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			vld_q <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		// fold left half plane onto the right
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in[DW-1]) begin
			x_s[0] <= -xw;
			y_s[0] <= -yw;
			z_s[0] <= HALF_TURN;
		end else begin
			x_s[0] <= xw;
			y_s[0] <= yw;
			z_s[0] <= '0;
		end
		// one vectoring micro-rotation per stage
		for (int k = 0; k < NSTEP; k++) begin
			zero_s[k+1] <= zero_s[k];
			if (!y_s[k][CW-1]) begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + ATAN_TURN[k];
			end else begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - ATAN_TURN[k];
			end
		end
		ang_q <= zero_s[NSTEP] ? '0 : rsum[31 -: ANGLE_BITS];
	end

	assign bear = '{vld: vld_q, angle: ang_q};

endmodule

// ===== rtl/psec_dist.sv =====
module psec_dist (
	input  logic                           clk,
	input  logic signed [psec_pkg::DW-1:0] dx,
	input  logic signed [psec_pkg::DW-1:0] dy,
	input  logic [22:0]                    reach,
	output logic                           far
);
	import psec_pkg::*;

	logic signed [2*DW-1:0] dxx_w;
	logic signed [2*DW-1:0] dyy_w;
	logic [SQW:0]           d2_w;
	logic [SQW-1:0]         dxx_s1;
	logic [SQW-1:0]         dyy_s1;
	logic [45:0]            r2_q;
	logic                   far_s2;
	logic                   far_dl_q [NSTEP];

	assign dxx_w = dx * dx;
	assign dyy_w = dy * dy;
	assign d2_w  = {1'b0, dxx_s1} + {1'b0, dyy_s1};

	always_ff @(posedge clk) begin
		dxx_s1 <= dxx_w[SQW-1:0];
		dyy_s1 <= dyy_w[SQW-1:0];
		r2_q   <= reach * reach;
		far_s2 <= d2_w > (SQW+1)'(r2_q);
		// align with the cordic latency
		far_dl_q[0] <= far_s2;
		for (int k = 1; k < NSTEP; k++) begin
			far_dl_q[k] <= far_dl_q[k-1];
		end
	end

	assign far = far_dl_q[NSTEP-1];

endmodule

// ===== rtl/point_in_sector_test.sv =====
// point in circular sector test. one point per clock: a transaction is taken at every
// rising edge with start high, busy is never raised, and the answer comes out on
// inside_res with a one-cycle done strobe, in order. a point passes the difference
// stage, the pipelined cordic with one micro-rotation per stage, and the bounds and
// compare stages. the receiver cannot stall, so nothing is held back. the sector is set
// through the apb registers (apex, axis vector, radius, half angle in degrees); write
// them only while no point is in flight.
// register map, 32-bit words: 0x00 center_x, 0x04 center_y, 0x08 axis_x, 0x0c axis_y,
// 0x10 reach, 0x14 half_angle_deg. other addresses read zero and ignore writes.
module point_in_sector_test (
	input  logic                             clk,
	input  logic                             arst_n,
	// apb configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [psec_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// point transaction
	input  logic                             start,
	output logic                             busy,
	input  logic signed [23:0]               point_x,
	input  logic signed [23:0]               point_y,
	// result transaction
	output logic                             done,
	output logic                             inside_res
);
	import psec_pkg::*;

	typedef enum logic [2:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_AXIS_X,
		REG_AXIS_Y,
		REG_REACH,
		REG_HALF_ANGLE
	} reg_idx_t;

	// configuration registers
	logic signed [23:0] center_x_q;
	logic signed [23:0] center_y_q;
	logic signed [15:0] axis_x_q;
	logic signed [15:0] axis_y_q;
	logic [22:0]        reach_q;
	logic [14:0]        half_angle_deg_q;

	// half angle as a turn fraction, derived from the register and settled long before use
	logic [HSW-1:0]        hsc_w;
	logic [HNW-1:0]        hn_q;
	logic [HNW+RCW-1:0]    hp_q;
	logic [ANGLE_BITS-1:0] h_w;

	// stage 1: offset from the apex
	logic                 vld_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;

	// bearings and radius check
	bear_t pb;
	bear_t ab;
	logic  far;

	// stage 2: arc bounds
	logic                  vld_s2;
	logic                  far_s2;
	logic [ANGLE_BITS-1:0] p_s2;
	logic [ANGLE_BITS-1:0] lo_s2;
	logic [ANGLE_BITS-1:0] hi_s2;
	logic                  in_arc;

	logic                  wr_en;
	logic [2:0]            widx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = paddr[ADDR_W-1:2];

	// register write, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q       <= '0;
			center_y_q       <= '0;
			axis_x_q         <= 16'sd16384;
			axis_y_q         <= '0;
			reach_q          <= 23'd25600;
			half_angle_deg_q <= 15'd7680;
		end else if (wr_en) begin
			unique case (widx)
				REG_CENTER_X:   center_x_q       <= pwdata[23:0];
				REG_CENTER_Y:   center_y_q       <= pwdata[23:0];
				REG_AXIS_X:     axis_x_q         <= pwdata[15:0];
				REG_AXIS_Y:     axis_y_q         <= pwdata[15:0];
				REG_REACH:      reach_q          <= pwdata[22:0];
				REG_HALF_ANGLE: half_angle_deg_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// register readback, zero extended
	always_comb begin
		unique case (widx)
			REG_CENTER_X:   prdata = {8'd0, center_x_q};
			REG_CENTER_Y:   prdata = {8'd0, center_y_q};
			REG_AXIS_X:     prdata = {16'd0, axis_x_q};
			REG_AXIS_Y:     prdata = {16'd0, axis_y_q};
			REG_REACH:      prdata = {9'd0, reach_q};
			REG_HALF_ANGLE: prdata = {17'd0, half_angle_deg_q};
			default:        prdata = '0;
		endcase
	end

	// round half up of deg * 2^angle_bits / full turn, divide by 45 as reciprocal multiply
	assign hsc_w = (HSW'(half_angle_deg_q) << ANGLE_BITS) + HSW'(DEG_BIAS);
	assign h_w   = hp_q[RCK +: ANGLE_BITS];

	always_ff @(posedge clk) begin
		hn_q <= hsc_w[HSW-1:DEG_SH];
		hp_q <= hn_q * RECIP;
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// exact 25-bit differences
	always_ff @(posedge clk) begin
		dx_s1 <= {point_x[23], point_x} - {center_x_q[23], center_x_q};
		dy_s1 <= {point_y[23], point_y} - {center_y_q[23], center_y_q};
	end

	// bearing of the point seen from the apex
	psec_cordic u_pt_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld_s1),
		.x_in   (dx_s1),
		.y_in   (dy_s1),
		.bear   (pb)
	);

	// bearing of the axis, carried alongside each point
	psec_cordic u_ax_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld_s1),
		.x_in   ({{(DW-16){axis_x_q[15]}}, axis_x_q}),
		.y_in   ({{(DW-16){axis_y_q[15]}}, axis_y_q}),
		.bear   (ab)
	);

	// squared distance against squared radius, delayed to meet the bearings
	psec_dist u_dist (
		.clk   (clk),
		.dx    (dx_s1),
		.dy    (dy_s1),
		.reach (reach_q),
		.far   (far)
	);

	// stage 2 and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s2 <= pb.vld;
			done   <= vld_s2;
		end
	end

	// start and end bounds wrap modulo a full turn
	always_ff @(posedge clk) begin
		far_s2 <= far;
		p_s2   <= pb.angle;
		lo_s2  <= ab.angle - h_w;
		hi_s2  <= ab.angle + h_w;
	end

	// inclusive test, wrapped arc when start exceeds end
	assign in_arc = (lo_s2 <= hi_s2) ? ((p_s2 >= lo_s2) && (p_s2 <= hi_s2))
	                                 : ((p_s2 >= lo_s2) || (p_s2 <= hi_s2));

	always_ff @(posedge clk) begin
		inside_res <= !far_s2 && in_arc;
	end

`ifndef SYNTHESIS
	// both cordic pipes carry the same transaction
	a_bear_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pb.vld == ab.vld)
		else $error("point and axis bearings out of step");

	// every accepted point gives a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(NSTEP + 5) done)
		else $error("result missing after accepted point");

	// no result without a matching accepted point
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, NSTEP + 5))
		else $error("result without accepted point");
`endif

endmodule
